// ===== hw/rtl/chained_matrix_multiply_defines.svh =====
// ============================================================================
// Assertion macros for the chained matrix multiplier
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ============================================================================
`ifndef CHAINED_MATRIX_MULTIPLY_DEFINES_SVH
`define CHAINED_MATRIX_MULTIPLY_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define CMM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante
`define CMM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/cmm_pkg.sv =====
// ============================================================================
// cmm_pkg
// Types, field layout and helpers shared by the chained matrix multiplier.
// ============================================================================
`timescale 1ns / 1ps

package cmm_pkg;

   // Payload field widths
   localparam int KIND_W  = 2;
   localparam int IDX_W   = 3;
   localparam int DATA_W  = 32;
   localparam int DIM_W   = 4;
   localparam int CSR_IDX_W = 2;

   // Stream data layout, lowest bit first: row, column, value, zero fill
   localparam int ROW_LSB = 0;
   localparam int COL_LSB = ROW_LSB + IDX_W;
   localparam int VAL_LSB = COL_LSB + IDX_W;
   localparam int FIELD_W = VAL_LSB + DATA_W;
   localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;
   localparam int PAD_W   = TDATA_W - FIELD_W;

   // Dimension register reset values
   localparam logic [DIM_W-1:0] ROWS_LEFT_RST  = 4'd5;
   localparam logic [DIM_W-1:0] INNER_SIZE_RST = 4'd2;
   localparam logic [DIM_W-1:0] COLS_RIGHT_RST = 4'd3;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_LEFT  = 2'd0,
      KIND_LOAD_RIGHT = 2'd1,
      KIND_MULTIPLY   = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_LEFT  = 2'd0,
      CSR_INNER_SIZE = 2'd1,
      CSR_COLS_RIGHT = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_EMIT,
      ST_WRITEBACK
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic issue;       // read one A/B pair for the current sum
      logic first;       // that pair opens a new sum
      logic emit;        // move the finished sum to the output and row buffer
      logic last;        // the emitted element closes the product
      logic writeback;   // copy one row buffer entry over A
      logic load_left;   // store the request element into A
      logic load_right;  // store the request element into B
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pipe_busy;   // products still in flight toward the accumulator
      logic out_free;    // output register can take an element this cycle
   } status_type;

   // Saturate a dimension register to 1..lim
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = 4'd1;
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/cmm_ctrl.sv =====
// ============================================================================
// cmm_ctrl
// Sequencer for loads, multiply-accumulate passes, emission and write-back.
// ============================================================================
`timescale 1ns / 1ps
`include "chained_matrix_multiply_defines.svh"

module cmm_ctrl import cmm_pkg::*; #(
   parameter int DIM_BITS = 3,
   parameter int CNT_BITS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [KIND_W-1:0]   req_tuser,
   input  logic [CNT_BITS-1:0] rows,
   input  logic [CNT_BITS-1:0] inner,
   input  logic [CNT_BITS-1:0] cols,
   input  status_type          status,
   output cmd_type             cmd,
   output logic [DIM_BITS-1:0] row_sel,
   output logic [DIM_BITS-1:0] inner_sel,
   output logic [DIM_BITS-1:0] col_sel
);

   state_type           state_ff, state_in;
   logic [DIM_BITS-1:0] i_ff, i_in;
   logic [DIM_BITS-1:0] j_ff, j_in;
   logic [DIM_BITS-1:0] k_ff, k_in;
   logic                accepted;
   kind_type            kind;
   logic                i_last, j_last, k_last;
   logic                emit_ok;

   assign req_tready = (state_ff == ST_IDLE);
   assign accepted   = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);

   assign i_last  = (CNT_BITS'(i_ff) == rows  - 1'b1);
   assign j_last  = (CNT_BITS'(j_ff) == inner - 1'b1);
   assign k_last  = (CNT_BITS'(k_ff) == cols  - 1'b1);
   assign emit_ok = !status.pipe_busy && status.out_free;

   assign row_sel   = i_ff;
   assign inner_sel = j_ff;
   assign col_sel   = k_ff;

   // Next state and loop counters
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accepted && kind == KIND_MULTIPLY) begin
               state_in = ST_MAC;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_MAC: begin
            if (j_last) begin
               j_in     = '0;
               state_in = ST_EMIT;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (emit_ok) begin
               if (k_last) begin
                  k_in     = '0;
                  state_in = ST_WRITEBACK;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_MAC;
               end
            end
         end
         ST_WRITEBACK: begin
            if (k_last) begin
               k_in = '0;
               if (i_last) begin
                  i_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_MAC;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_left  = accepted && kind == KIND_LOAD_LEFT;
            cmd.load_right = accepted && kind == KIND_LOAD_RIGHT;
         end
         ST_MAC: begin
            cmd.issue = 1'b1;
            cmd.first = (j_ff == '0);
         end
         ST_EMIT: begin
            cmd.emit = emit_ok;
            cmd.last = i_last && k_last;
         end
         ST_WRITEBACK: begin
            cmd.writeback = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   `CMM_ASSERT_IMP(a_out_bounds, state_ff != ST_IDLE, CNT_BITS'(i_ff) < rows && CNT_BITS'(k_ff) < cols, "product index beyond configured size")
   `CMM_ASSERT_IMP(a_inner_bound, state_ff == ST_MAC, CNT_BITS'(j_ff) < inner, "inner index beyond configured size")
   `CMM_ASSERT_NXT(a_last_wb, cmd.emit && cmd.last, state_ff == ST_WRITEBACK, "final element not followed by write-back")

endmodule

// ===== hw/rtl/cmm_dpath.sv =====
// ============================================================================
// cmm_dpath
// Operand stores, multiply-accumulate pipeline, row buffer and output register.
// ============================================================================
`timescale 1ns / 1ps
`include "chained_matrix_multiply_defines.svh"

module cmm_dpath import cmm_pkg::*; #(
   parameter int MAX_DIM  = 8,
   parameter int DIM_BITS = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [TDATA_W-1:0]  req_tdata,
   input  cmd_type             cmd,
   input  logic [DIM_BITS-1:0] row_sel,
   input  logic [DIM_BITS-1:0] inner_sel,
   input  logic [DIM_BITS-1:0] col_sel,
   output status_type          status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata,   // out_row, out_col, product_value, zero fill
   output logic                rsp_tlast
);

   localparam int ADDR_BITS   = 2 * DIM_BITS;
   localparam int STORE_DEPTH = 1 << ADDR_BITS;
   localparam int ROWBUF_DEPTH = 1 << DIM_BITS;
   localparam logic [IDX_W:0] DIM_LIM = (IDX_W + 1)'(MAX_DIM);

   logic [DATA_W-1:0] left_mem  [STORE_DEPTH];
   logic [DATA_W-1:0] right_mem [STORE_DEPTH];
   logic [DATA_W-1:0] row_buf_ff [ROWBUF_DEPTH];

   logic [IDX_W-1:0]     req_row, req_col;
   logic [DATA_W-1:0]    req_value;
   logic                 in_range;
   logic [ADDR_BITS-1:0] load_addr;
   logic                 lw_en, rw_en;
   logic [ADDR_BITS-1:0] lw_addr;
   logic [DATA_W-1:0]    lw_data;

   logic [DATA_W-1:0] rd_left_ff, rd_right_ff;
   logic              st1_valid_ff, st1_first_ff;
   logic              st2_valid_ff, st2_first_ff;
   logic [DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] acc_ff, acc_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    rsp_row_ff, rsp_col_ff;
   logic [DATA_W-1:0]   rsp_value_ff;
   logic                rsp_last_ff;

   // Unpack the request element
   assign req_row   = req_tdata[ROW_LSB +: IDX_W];
   assign req_col   = req_tdata[COL_LSB +: IDX_W];
   assign req_value = req_tdata[VAL_LSB +: DATA_W];
   assign in_range  = ({1'b0, req_row} < DIM_LIM) && ({1'b0, req_col} < DIM_LIM);
   assign load_addr = {req_row[DIM_BITS-1:0], req_col[DIM_BITS-1:0]};

   // A is written by loads and by the product write-back
   assign lw_en   = (cmd.load_left && in_range) || cmd.writeback;
   assign lw_addr = cmd.writeback ? {row_sel, col_sel} : load_addr;
   assign lw_data = cmd.writeback ? row_buf_ff[col_sel] : req_value;
   assign rw_en   = cmd.load_right && in_range;

   always_ff @(posedge clock) begin
      if (lw_en) begin
         left_mem[lw_addr] <= lw_data;
      end
      rd_left_ff <= left_mem[{row_sel, inner_sel}];
   end

   always_ff @(posedge clock) begin
      if (rw_en) begin
         right_mem[load_addr] <= req_value;
      end
      rd_right_ff <= right_mem[{inner_sel, col_sel}];
   end

   // Multiply, then accumulate; the sum wraps to the data width
   assign prod_in = DATA_W'(rd_left_ff * rd_right_ff);
   assign acc_in  = st2_first_ff ? prod_ff : acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
      end else begin
         st1_valid_ff <= cmd.issue;
         st2_valid_ff <= st1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      st1_first_ff <= cmd.first;
      st2_first_ff <= st1_first_ff;
      prod_ff      <= prod_in;
      if (st2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Hold the current product row until it is copied over A
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         row_buf_ff[col_sel] <= acc_ff;
      end
   end

   // Output register: load on emit, drop after the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_row_ff   <= IDX_W'(row_sel);
         rsp_col_ff   <= IDX_W'(col_sel);
         rsp_value_ff <= acc_ff;
         rsp_last_ff  <= cmd.last;
      end
   end

   assign status.pipe_busy = st1_valid_ff || st2_valid_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_value_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

   `CMM_ASSERT_IMP(a_emit_ready, cmd.emit, !status.pipe_busy && status.out_free, "emit while sum in flight or output full")

endmodule

// ===== hw/rtl/chained_matrix_multiply.sv =====
// ============================================================================
// chained_matrix_multiply
// Integer matrix multiplier whose product replaces the left operand.
// ============================================================================
// Load items (kind 0 for A, kind 1 for B) store one element each and are taken
// one per cycle while the block is idle. A multiply item (kind 2) computes
// C = A x B over the configured sizes m x n x p, saturated to 1..MAX_DIM, with
// 32-bit wrap-around, sends C in row-major order with tlast on the final
// element, and copies each row of C over the same row of A so the next multiply
// continues the chain. A multiply holds the request side until it is done: each
// element is summed on the single multiply-accumulate unit through the memory
// read and multiplier pipeline and handed to the output register, and each row
// is then written back through the one write port of the A store. The output
// register lets the next element be computed while the previous one waits for
// rsp_tready. Dimensions must be written through the csr port only while the
// block is idle; the block does not enforce this. Stores come up undefined.
`timescale 1ns / 1ps

module chained_matrix_multiply import cmm_pkg::*; #(
   parameter int MAX_DIM = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,   // row_index, col_index, element_value, zero fill
   input  logic [KIND_W-1:0]    req_tuser,   // kind
   // Result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata,   // out_row, out_col, product_value, zero fill
   output logic                 rsp_tlast,
   // Dimension register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   localparam int DIM_BITS = $clog2(MAX_DIM);
   localparam int CNT_BITS = $clog2(MAX_DIM + 1);
   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

   logic [DIM_W-1:0]    rows_left_ff, inner_size_ff, cols_right_ff;
   logic [CNT_BITS-1:0] rows, inner, cols;
   logic                csr_write;
   cmd_type             cmd;
   status_type          status;
   logic [DIM_BITS-1:0] row_sel, inner_sel, col_sel;

   // Dimension registers keep the written bits; saturation applies on use
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_left_ff  <= ROWS_LEFT_RST;
         inner_size_ff <= INNER_SIZE_RST;
         cols_right_ff <= COLS_RIGHT_RST;
      end else if (csr_write) begin
         case (csr_reg_type'(csr_index))
            CSR_ROWS_LEFT:  rows_left_ff  <= csr_data;
            CSR_INNER_SIZE: inner_size_ff <= csr_data;
            CSR_COLS_RIGHT: cols_right_ff <= csr_data;
            default: begin
               // unknown index: drop the transfer
            end
         endcase
      end
   end

   assign rows  = CNT_BITS'(clamp_dim(rows_left_ff,  DIM_MAX));
   assign inner = CNT_BITS'(clamp_dim(inner_size_ff, DIM_MAX));
   assign cols  = CNT_BITS'(clamp_dim(cols_right_ff, DIM_MAX));

   cmm_ctrl #(
      .DIM_BITS (DIM_BITS),
      .CNT_BITS (CNT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rows       (rows),
      .inner      (inner),
      .cols       (cols),
      .status     (status),
      .cmd        (cmd),
      .row_sel    (row_sel),
      .inner_sel  (inner_sel),
      .col_sel    (col_sel)
   );

   cmm_dpath #(
      .MAX_DIM  (MAX_DIM),
      .DIM_BITS (DIM_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .row_sel    (row_sel),
      .inner_sel  (inner_sel),
      .col_sel    (col_sel),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== dv/tb_top.sv =====
// ============================================================================
// tb_top: chained matrix multiplier testbench
// Drives element loads, multiplies and dimension writes into the block and
// checks every product element against a predictor that keeps its own copy
// of A, B and the dimension registers, including the write-back of C over A.
// A short directed table covers the arithmetic extremes, ignored fields,
// saturated dimensions and the unused kind and register index. Random phases
// follow, each one programming new sizes and running a short chain.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
   import cmm_pkg::*;

   localparam int MAX_DIM          = 8;
   localparam int RANDOM_REQUESTS  = 380;
   localparam int SETTLE_CYCLES    = 64;
   localparam int DRAIN_LIMIT      = 20000;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int PRESSURE_PHASE   = 2;
   localparam int MAX_REPORTS      = 10;
   localparam int DIRECTED_STEPS   = 20;
   localparam int RUN_LIMIT_NS     = 20_000_000;

   // Codes that the package leaves without a name
   localparam logic [KIND_W-1:0]    KIND_UNUSED    = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   typedef struct packed {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] value;
      logic              last;
   } product_type;

   typedef enum logic [1:0] {
      STEP_ITEM,
      STEP_REG,
      STEP_FILL
   } step_kind_type;

   typedef struct packed {
      step_kind_type         step;
      logic [KIND_W-1:0]     kind;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [IDX_W-1:0]      row;
      logic [IDX_W-1:0]      col;
      logic [DATA_W-1:0]     value;
      logic                  typed;
      logic [DATA_W-1:0]     typed_value;
   } step_type;

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_tvalid  = 1'b0;
   logic                 req_tready;
   logic [TDATA_W-1:0]   req_tdata   = '0;   // row_index, col_index, element_value, zero fill
   logic [KIND_W-1:0]    req_tuser   = '0;   // kind
   logic                 rsp_tvalid;
   logic                 rsp_tready  = 1'b0;
   logic [TDATA_W-1:0]   rsp_tdata;          // out_row, out_col, product_value, zero fill
   logic                 rsp_tlast;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [DIM_W-1:0]     csr_data    = '0;

   // Predictor state
   logic [DATA_W-1:0] left_mat     [MAX_DIM*MAX_DIM];
   logic [DATA_W-1:0] right_mat    [MAX_DIM*MAX_DIM];
   bit                left_written [MAX_DIM*MAX_DIM];
   bit                right_written[MAX_DIM*MAX_DIM];
   logic [DIM_W-1:0]  rows_cfg  = ROWS_LEFT_RST;
   logic [DIM_W-1:0]  inner_cfg = INNER_SIZE_RST;
   logic [DIM_W-1:0]  cols_cfg  = COLS_RIGHT_RST;

   product_type pending_products[$];

   step_type directed_steps [DIRECTED_STEPS];

   int  failures         = 0;
   int  requests_sent    = 0;
   int  multiplies_sent  = 0;
   int  products_checked = 0;
   int  largest_product  = 0;
   int  settings_count   = 0;
   int  phase_no         = 0;
   int  send_run         = 0;
   int  recv_run         = 0;
   logic rsp_hold_off    = 1'b0;

   chained_matrix_multiply #(
      .MAX_DIM(MAX_DIM)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("Run limit reached, %0d product elements outstanding",
               pending_products.size());
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("[%0t] %s", $time, msg);
      end
   endfunction

   function automatic string show_product(input product_type pr);
      return $sformatf("row %0d col %0d value 0x%08h last %0d",
                       pr.row, pr.col, pr.value, pr.last);
   endfunction

   // Saturate a raw dimension register to 1..MAX_DIM
   function automatic int dim_in_use(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (v > MAX_DIM) begin
         return MAX_DIM;
      end
      return int'(v);
   endfunction

   // Store an element, or form C = A x B, emit it and copy each row over A
   function automatic void apply_request(input logic [KIND_W-1:0] kind,
                                         input logic [IDX_W-1:0] row,
                                         input logic [IDX_W-1:0] col,
                                         input logic [DATA_W-1:0] value,
                                         ref product_type results[$]);
      int m, n, p, i, j, k, at;
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] row_sums [MAX_DIM];
      at = int'(row) * MAX_DIM + int'(col);
      case (kind)
         KIND_LOAD_LEFT: begin
            left_mat[at]     = value;
            left_written[at] = 1'b1;
         end
         KIND_LOAD_RIGHT: begin
            right_mat[at]     = value;
            right_written[at] = 1'b1;
         end
         KIND_MULTIPLY: begin
            m = dim_in_use(rows_cfg);
            n = dim_in_use(inner_cfg);
            p = dim_in_use(cols_cfg);
            if (m * p > largest_product) begin
               largest_product = m * p;
            end
            for (i = 0; i < m; i++) begin
               for (k = 0; k < p; k++) begin
                  acc = '0;
                  for (j = 0; j < n; j++) begin
                     acc = acc + left_mat[i*MAX_DIM+j] * right_mat[j*MAX_DIM+k];
                  end
                  row_sums[k] = acc;
                  results.push_back('{row: i[IDX_W-1:0], col: k[IDX_W-1:0], value: acc,
                                      last: (i == m - 1 && k == p - 1)});
               end
               for (k = 0; k < p; k++) begin
                  left_mat[i*MAX_DIM+k]     = row_sums[k];
                  left_written[i*MAX_DIM+k] = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Gap before the next transfer; now and then a run with no gaps at all
   function automatic int draw_gap(inout int run);
      if (run > 0) begin
         run--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         run = $urandom_range(16, 48);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [DATA_W-1:0] draw_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 32'd1;
         2:       return '1;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h8000_0000;
         5:       return $urandom_range(0, 31) - 16;
         default: return $urandom;
      endcase
   endfunction

   // Mostly small sizes, a few full ones, a few that saturate
   function automatic logic [DIM_W-1:0] draw_dim();
      int pick;
      logic [DIM_W-1:0] d;
      pick = $urandom_range(0, 15);
      if (pick < 10) begin
         d = DIM_W'($urandom_range(1, 4));
      end else if (pick < 13) begin
         d = DIM_W'($urandom_range(5, 8));
      end else if (pick == 13) begin
         d = '0;
      end else begin
         d = DIM_W'($urandom_range(9, 15));
      end
      return d;
   endfunction

   function automatic step_type item_step(input logic [KIND_W-1:0] kind,
                                          input logic [IDX_W-1:0] row,
                                          input logic [IDX_W-1:0] col,
                                          input logic [DATA_W-1:0] value);
      return '{step: STEP_ITEM, kind: kind, reg_index: '0, row: row, col: col,
               value: value, typed: 1'b0, typed_value: '0};
   endfunction

   // 1x1x1 multiply whose single element is known in advance
   function automatic step_type typed_multiply(input logic [DATA_W-1:0] product);
      return '{step: STEP_ITEM, kind: KIND_MULTIPLY, reg_index: '0, row: '0, col: '0,
               value: '0, typed: 1'b1, typed_value: product};
   endfunction

   function automatic step_type reg_step(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [DIM_W-1:0] data);
      return '{step: STEP_REG, kind: '0, reg_index: idx, row: '0, col: '0,
               value: DATA_W'(data), typed: 1'b0, typed_value: '0};
   endfunction

   // Offer one request, hold it until the transfer, then predict
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [IDX_W-1:0] row,
                               input logic [IDX_W-1:0] col,
                               input logic [DATA_W-1:0] value,
                               input logic typed,
                               input logic [DATA_W-1:0] typed_value);
      int gap;
      product_type results[$];
      gap = draw_gap(send_run);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{PAD_W{1'b0}}, value, col, row};
      do @(posedge clock); while (req_tready !== 1'b1);
      apply_request(kind, row, col, value, results);
      if (typed) begin
         pending_products.push_back('{row: '0, col: '0, value: typed_value, last: 1'b1});
      end else begin
         foreach (results[q]) pending_products.push_back(results[q]);
      end
      if (kind != KIND_UNUSED) begin
         requests_sent++;
      end
      if (kind == KIND_MULTIPLY) begin
         multiplies_sent++;
      end
   endtask

   // Raise the register channel and hold it until the transfer
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_ROWS_LEFT:  rows_cfg  = data;
         CSR_INNER_SIZE: inner_cfg = data;
         CSR_COLS_RIGHT: cols_cfg  = data;
         default: begin
         end
      endcase
   endtask

   // Drop the request side, drain all products, let write-back finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Load every operand that the next multiply reads and that is still unset
   task automatic load_missing_operands();
      int m, n, p, i, j;
      m = dim_in_use(rows_cfg);
      n = dim_in_use(inner_cfg);
      p = dim_in_use(cols_cfg);
      for (i = 0; i < m; i++) begin
         for (j = 0; j < n; j++) begin
            if (!left_written[i*MAX_DIM+j]) begin
               send_request(KIND_LOAD_LEFT, i[IDX_W-1:0], j[IDX_W-1:0], draw_value(),
                            1'b0, '0);
            end
         end
      end
      for (i = 0; i < n; i++) begin
         for (j = 0; j < p; j++) begin
            if (!right_written[i*MAX_DIM+j]) begin
               send_request(KIND_LOAD_RIGHT, i[IDX_W-1:0], j[IDX_W-1:0], draw_value(),
                            1'b0, '0);
            end
         end
      end
   endtask

   // Stray loads anywhere in the stores and items of the unused kind
   task automatic send_noise();
      logic [KIND_W-1:0] kind;
      case ($urandom_range(0, 4))
         0, 1:    kind = KIND_LOAD_LEFT;
         2, 3:    kind = KIND_LOAD_RIGHT;
         default: kind = KIND_UNUSED;
      endcase
      send_request(kind, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                   draw_value(), 1'b0, '0);
   endtask

   // Receiver: random stalls, a long hold-off on request, check each transfer
   initial begin : drain_products
      int stall;
      product_type got;
      product_type want;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = draw_gap(recv_run);
         if (stall > 0 || rsp_hold_off) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (rsp_hold_off) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got.row   = rsp_tdata[ROW_LSB +: IDX_W];
         got.col   = rsp_tdata[COL_LSB +: IDX_W];
         got.value = rsp_tdata[VAL_LSB +: DATA_W];
         got.last  = rsp_tlast;
         products_checked++;
         if (pending_products.size() == 0) begin
            note_failure({"product element with none pending: ", show_product(got)});
         end else begin
            want = pending_products.pop_front();
            if (got.row !== want.row || got.col !== want.col ||
                got.value !== want.value || got.last !== want.last) begin
               note_failure({"mismatch: expected ", show_product(want),
                             ", got ", show_product(got)});
            end
         end
      end
   end

   // Hold the result side off for a long stretch during one phase
   initial begin : result_hold_off
      wait (phase_no == PRESSURE_PHASE);
      @(posedge clock);
      rsp_hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      rsp_hold_off <= 1'b0;
   end

   // Main sequence
   initial begin : stimulus
      int s, w, rounds, random_start;
      logic [DIM_W-1:0] r_dim, i_dim, c_dim;

      directed_steps = '{
         '{step: STEP_FILL, kind: '0, reg_index: '0, row: '0, col: '0, value: '0,
           typed: 1'b0, typed_value: '0},
         // multiply at the reset sizes, ignored fields at their extremes
         item_step(KIND_MULTIPLY, 3'd7, 3'd7, 32'hFFFF_FFFF),
         // zero sizes saturate to 1x1x1
         reg_step(CSR_ROWS_LEFT, 4'd0),
         reg_step(CSR_INNER_SIZE, 4'd0),
         reg_step(CSR_COLS_RIGHT, 4'd0),
         item_step(KIND_LOAD_LEFT, 3'd0, 3'd0, 32'h7FFF_FFFF),
         item_step(KIND_LOAD_RIGHT, 3'd0, 3'd0, 32'h7FFF_FFFF),
         typed_multiply(32'h0000_0001),
         // A now holds the previous product
         typed_multiply(32'h7FFF_FFFF),
         item_step(KIND_LOAD_LEFT, 3'd0, 3'd0, 32'h8000_0000),
         item_step(KIND_LOAD_RIGHT, 3'd0, 3'd0, 32'hFFFF_FFFF),
         typed_multiply(32'h8000_0000),
         // unused kind must leave both stores alone
         item_step(KIND_UNUSED, 3'd0, 3'd0, 32'h1234_5678),
         typed_multiply(32'h8000_0000),
         // unused register index must leave the sizes alone
         reg_step(CSR_UNUSED_IDX, 4'd8),
         typed_multiply(32'h8000_0000),
         item_step(KIND_LOAD_LEFT, 3'd7, 3'd7, 32'hFFFF_FFFF),
         item_step(KIND_LOAD_RIGHT, 3'd7, 3'd7, 32'h0000_0000),
         item_step(KIND_LOAD_LEFT, 3'd0, 3'd0, 32'h0000_0000),
         typed_multiply(32'h0000_0000)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      for (s = 0; s < DIRECTED_STEPS; s++) begin
         if (directed_steps[s].step == STEP_REG) begin
            if (s == 0 || directed_steps[s-1].step != STEP_REG) begin
               wait_idle();
               settings_count++;
            end
            write_reg(directed_steps[s].reg_index, directed_steps[s].value[DIM_W-1:0]);
         end else begin
            if (s > 0 && directed_steps[s-1].step == STEP_REG) begin
               csr_valid <= 1'b0;
            end
            if (directed_steps[s].step == STEP_FILL) begin
               load_missing_operands();
            end else begin
               send_request(directed_steps[s].kind, directed_steps[s].row,
                            directed_steps[s].col, directed_steps[s].value,
                            directed_steps[s].typed, directed_steps[s].typed_value);
            end
         end
      end

      // Random phases: new sizes, then a short chain of multiplies
      random_start = requests_sent;
      while (requests_sent - random_start < RANDOM_REQUESTS) begin
         wait_idle();
         case (phase_no + 1)
            1: begin
               r_dim = 4'd15;
               i_dim = 4'd9;
               c_dim = 4'd12;
            end
            PRESSURE_PHASE: begin
               r_dim = 4'd4;
               i_dim = 4'd4;
               c_dim = 4'd4;
            end
            default: begin
               r_dim = draw_dim();
               i_dim = $urandom_range(0, 1) ? cols_cfg : draw_dim();
               c_dim = draw_dim();
            end
         endcase
         write_reg(CSR_ROWS_LEFT, r_dim);
         write_reg(CSR_INNER_SIZE, i_dim);
         write_reg(CSR_COLS_RIGHT, c_dim);
         if ($urandom_range(0, 5) == 0) begin
            write_reg(CSR_UNUSED_IDX, DIM_W'($urandom));
         end
         csr_valid <= 1'b0;
         settings_count++;
         phase_no++;
         rounds = (phase_no == PRESSURE_PHASE) ? 3 : $urandom_range(1, 3);
         repeat (rounds) begin
            repeat ($urandom_range(0, 3)) send_noise();
            load_missing_operands();
            send_request(KIND_MULTIPLY, IDX_W'($urandom), IDX_W'($urandom), $urandom,
                         1'b0, '0);
         end
      end

      // Drain and settle
      req_tvalid <= 1'b0;
      for (w = 0; w < DRAIN_LIMIT && pending_products.size() != 0; w++) begin
         @(posedge clock);
      end
      if (pending_products.size() != 0) begin
         note_failure($sformatf("%0d product elements never arrived",
                                pending_products.size()));
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d load and multiply requests, %0d multiplies, largest product %0d",
               requests_sent, multiplies_sent, largest_product);
      $display("over %0d size settings; %0d product elements compared, %0d failures",
               settings_count, products_checked, failures);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cmm_pkg.sv
hw/rtl/cmm_ctrl.sv
hw/rtl/cmm_dpath.sv
hw/rtl/chained_matrix_multiply.sv
dv/tb_top.sv
